/* sv/fss_pkg.sv */
`timescale 1ns / 1ps

package fss_pkg;

    localparam int DUTY_W     = 16;
    localparam int INTERVAL_W = 8;
    localparam int DELAY_W    = 7;
    localparam int SEQ_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 40;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD      = 3'd0,
        CFG_LOW_DUTY_THRESH = 3'd1,
        CFG_DUTY_STEP       = 3'd2,
        CFG_FAST_INTERVAL   = 3'd3,
        CFG_SLOW_INTERVAL   = 3'd4,
        CFG_POWER_ON_DELAY  = 3'd5,
        CFG_POWER_OFF_DELAY = 3'd6
    } cfg_idx_t;

    localparam logic [DUTY_W-1:0]     RST_PWM_PERIOD      = 16'd1600;
    localparam logic [DUTY_W-1:0]     RST_LOW_DUTY_THRESH = 16'd160;
    localparam logic [DUTY_W-1:0]     RST_DUTY_STEP       = 16'd1;
    localparam logic [INTERVAL_W-1:0] RST_FAST_INTERVAL   = 8'd1;
    localparam logic [INTERVAL_W-1:0] RST_SLOW_INTERVAL   = 8'd10;
    localparam logic [DELAY_W-1:0]    RST_POWER_ON_DELAY  = 7'd5;
    localparam logic [DELAY_W-1:0]    RST_POWER_OFF_DELAY = 7'd50;

    localparam logic [INTERVAL_W-1:0] RAMP_COUNT_MAX = '1;

    typedef struct packed {
        logic [DUTY_W-1:0]     pwm_period;
        logic [DUTY_W-1:0]     low_duty_threshold;
        logic [DUTY_W-1:0]     duty_step;
        logic [INTERVAL_W-1:0] fast_interval;
        logic [INTERVAL_W-1:0] slow_interval;
        logic [DELAY_W-1:0]    power_on_delay;
        logic [DELAY_W-1:0]    power_off_delay;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] target_duty;
        logic              tick_fast;
        logic              tick_slow;
    } item_t;

    // Power sequencing status handed to the ramp.
    typedef struct packed {
        logic fan_power;
        logic pwm_allowed;
    } seq_status_t;

endpackage

/* sv/fss_seq.sv */
`timescale 1ns / 1ps

module fss_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic                                tick_slow,
    input  logic                                target_nonzero,
    input  logic [fss_pkg::DELAY_W-1:0]         power_on_delay,
    input  logic [fss_pkg::DELAY_W-1:0]         power_off_delay,
    output fss_pkg::seq_status_t                status_next
);
    import fss_pkg::*;

    logic signed [SEQ_W-1:0] seq_count_reg, seq_count_next;
    logic signed [SEQ_W-1:0] seq_base;
    logic signed [SEQ_W-1:0] on_limit, off_limit;
    seq_status_t             status_reg;

    assign on_limit  = signed'({1'b0, power_on_delay});
    assign off_limit = -signed'({1'b0, power_off_delay});

    always_comb begin
        seq_count_next = seq_count_reg;
        status_next    = status_reg;
        seq_base       = seq_count_reg;
        if (tick_slow) begin
            if (target_nonzero) begin
                status_next.fan_power = 1'b1;
                seq_base = (seq_count_reg < 0) ? '0 : seq_count_reg;
                if (seq_base < on_limit) begin
                    seq_count_next = seq_base + 8'sd1;
                end else begin
                    seq_count_next          = seq_base;
                    status_next.pwm_allowed = 1'b1;
                end
            end else begin
                status_next.pwm_allowed = 1'b0;
                seq_base = (seq_count_reg > 0) ? '0 : seq_count_reg;
                if (seq_base > off_limit) begin
                    seq_count_next = seq_base - 8'sd1;
                end else begin
                    seq_count_next        = seq_base;
                    status_next.fan_power = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_count_reg <= '0;
            status_reg    <= '0;
        end else if (step) begin
            seq_count_reg <= seq_count_next;
            status_reg    <= status_next;
        end
    end

endmodule

/* sv/fss_ramp.sv */
`timescale 1ns / 1ps

module fss_ramp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic [fss_pkg::DUTY_W-1:0]      target_duty,
    input  logic                            tick_fast,
    input  logic                            pwm_allowed,
    input  fss_pkg::cfg_t                   cfg,
    output logic [fss_pkg::DUTY_W-1:0]      duty_next,
    output logic [fss_pkg::DUTY_W-1:0]      compare_next,
    output logic                            channel_on_next
);
    import fss_pkg::*;

    logic [DUTY_W-1:0]     duty_reg;
    logic [INTERVAL_W-1:0] ramp_count_reg, ramp_count_next;
    logic [INTERVAL_W-1:0] count_inc, limit;
    logic                  going_up;
    logic [DUTY_W-1:0]     gap, stepped;

    assign count_inc = (ramp_count_reg == RAMP_COUNT_MAX) ? ramp_count_reg
                                                          : ramp_count_reg + 8'd1;
    assign limit    = (duty_reg < cfg.low_duty_threshold) ? cfg.fast_interval
                                                          : cfg.slow_interval;
    assign going_up = duty_reg < target_duty;
    assign gap      = going_up ? target_duty - duty_reg : duty_reg - target_duty;
    assign stepped  = going_up ? duty_reg + cfg.duty_step : duty_reg - cfg.duty_step;

    always_comb begin
        duty_next       = duty_reg;
        ramp_count_next = ramp_count_reg;
        if (target_duty == '0 || !pwm_allowed) begin
            duty_next       = '0;
            ramp_count_next = '0;
        end else if (duty_reg == target_duty) begin
            ramp_count_next = '0;
        end else if (tick_fast) begin
            if (count_inc < limit) begin
                ramp_count_next = count_inc;
            end else begin
                ramp_count_next = '0;
                // Clamp the last step so the duty lands exactly on the target.
                duty_next = (gap >= cfg.duty_step) ? stepped : target_duty;
            end
        end
    end

    always_comb begin
        channel_on_next = duty_next != '0;
        if (duty_next == '0) begin
            compare_next = '0;
        end else if (duty_next >= cfg.pwm_period) begin
            compare_next = cfg.pwm_period;
        end else begin
            compare_next = duty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg       <= '0;
            ramp_count_reg <= '0;
        end else if (step) begin
            duty_reg       <= duty_next;
            ramp_count_reg <= ramp_count_next;
        end
    end

endmodule

/* sv/fan_soft_start_sequencer.sv */
`timescale 1ns / 1ps

// Fan soft-start sequencer: power sequencing and a soft-start PWM duty ramp.
// Each input word is one control pass: the target duty and two tick flags
// (a fast tick and a slow tick). Each pass yields exactly one result word
// with the fan power level, the PWM permit, the ramped duty, the compare value
// for the PWM timer and the channel enable.
// The input word lands in an input register; once the output slot is free or
// being emptied, the sequencing and ramp logic update the state and the result
// is written to the output register, which drives m_tvalid. A new word can be
// taken every cycle, giving one result per cycle when the sink keeps m_tready
// high. The ramp updates its state once per pass, so it never holds the flow.
// When the sink stalls, the result stays in the output register and the input
// register still takes one more word; s_tready drops only when both are full.
// Reset (aresetn low at a clock edge) empties both registers, clears the duty,
// ramp and sequencing state, and loads the registers with their defaults.
// Configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at the
// next edge and are expected only while no pass is in flight.
module fan_soft_start_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input words.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] target_duty, [16] tick_fast, [17] tick_slow, [23:18] zero
    input  logic [fss_pkg::S_DATA_W-1:0]        s_tdata,
    // Result words.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] fan_power, [1] pwm_allowed, [17:2] present_duty,
    // [33:18] compare_value, [34] channel_on, [39:35] zero
    output logic [fss_pkg::M_DATA_W-1:0]        m_tdata,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [fss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import fss_pkg::*;

    cfg_t        cfg_reg;
    item_t       in_item_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic        advance;
    seq_status_t status_next;
    logic [DUTY_W-1:0] duty_next, compare_next;
    logic        channel_on_next;

    // A pass moves from the input register to the output register whenever
    // the output slot is empty or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pwm_period         <= RST_PWM_PERIOD;
            cfg_reg.low_duty_threshold <= RST_LOW_DUTY_THRESH;
            cfg_reg.duty_step          <= RST_DUTY_STEP;
            cfg_reg.fast_interval      <= RST_FAST_INTERVAL;
            cfg_reg.slow_interval      <= RST_SLOW_INTERVAL;
            cfg_reg.power_on_delay     <= RST_POWER_ON_DELAY;
            cfg_reg.power_off_delay    <= RST_POWER_OFF_DELAY;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_PWM_PERIOD:      cfg_reg.pwm_period         <= cfg_wdata;
                CFG_LOW_DUTY_THRESH: cfg_reg.low_duty_threshold <= cfg_wdata;
                CFG_DUTY_STEP:       cfg_reg.duty_step          <= cfg_wdata;
                CFG_FAST_INTERVAL:   cfg_reg.fast_interval   <= cfg_wdata[INTERVAL_W-1:0];
                CFG_SLOW_INTERVAL:   cfg_reg.slow_interval   <= cfg_wdata[INTERVAL_W-1:0];
                CFG_POWER_ON_DELAY:  cfg_reg.power_on_delay  <= cfg_wdata[DELAY_W-1:0];
                CFG_POWER_OFF_DELAY: cfg_reg.power_off_delay <= cfg_wdata[DELAY_W-1:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.target_duty <= s_tdata[DUTY_W-1:0];
            in_item_reg.tick_fast   <= s_tdata[DUTY_W];
            in_item_reg.tick_slow   <= s_tdata[DUTY_W+1];
        end
    end

    // Sequencing runs first so the ramp sees the permit of this pass.
    fss_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .tick_slow       (in_item_reg.tick_slow),
        .target_nonzero  (in_item_reg.target_duty != '0),
        .power_on_delay  (cfg_reg.power_on_delay),
        .power_off_delay (cfg_reg.power_off_delay),
        .status_next     (status_next)
    );

    fss_ramp u_ramp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .target_duty     (in_item_reg.target_duty),
        .tick_fast       (in_item_reg.tick_fast),
        .pwm_allowed     (status_next.pwm_allowed),
        .cfg             (cfg_reg),
        .duty_next       (duty_next),
        .compare_next    (compare_next),
        .channel_on_next (channel_on_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {5'd0, channel_on_next, compare_next, duty_next,
                             status_next.pwm_allowed, status_next.fan_power};
        end
    end

    // The channel enable follows the ramped duty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34] == (m_tdata[17:2] != 16'd0)))
        else $error("channel_on does not match present_duty");

    // PWM is never permitted with the fan supply off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("pwm_allowed without fan_power");

    // A nonzero duty only exists while PWM is permitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:2] != 16'd0) |-> m_tdata[1])
        else $error("nonzero duty without pwm_allowed");

    // The compare value never exceeds the duty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:18] <= m_tdata[17:2]))
        else $error("compare_value above present_duty");

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
